FILE: sv/assert_macros.svh
// Assertion macros used by the RTL of the base64 validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that one condition implies another in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: sv/b64v_pkg.sv
// Package of the base64 validator: widths, fail codes and the character decoder.
`timescale 1ns / 1ps
package b64v_pkg;

	localparam int MAX_CHARS = 1024;
	localparam int LEN_W = 11;
	localparam int SIZE_W = 10;
	localparam int IDX_W = 2;
	localparam int CFG_W = 11;

	localparam logic [IDX_W-1:0] REG_MAX_ENCODED = 2'd0;
	localparam logic [IDX_W-1:0] REG_MIN_DECODED = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_DECODED = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [LEN_W-1:0] MAX_CHARS_C = LEN_W'(MAX_CHARS);

	typedef enum logic [2:0] {
		FAIL_NONE     = 3'd0,
		FAIL_EMPTY    = 3'd1,
		FAIL_TOO_LONG = 3'd2,
		FAIL_LEN_MOD4 = 3'd3,
		FAIL_BAD_CHAR = 3'd4,
		FAIL_TAIL     = 3'd5,
		FAIL_SIZE     = 3'd6
	} fail_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] value;
	} sextet_t;

	// Map one raw byte to its base64 value; ok is low for anything else.
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok = 1'b1;
		r.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.value = 6'd62;
		end else if (c == 8'h2F) begin
			r.value = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: sv/canonical_base64_validator.sv
// Streaming canonical base64 validator: one beat per unstalled cycle, one verdict per string.
// Takes one character per cycle while in_stall is low; the verdict for a string passes from
// the input register into the result register once its end beat is accepted. Characters that
// do not end a string never wait on the output side; only an end beat held behind a stalled,
// still-full result register raises in_stall. Configuration writes must come while no beat is
// in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module canonical_base64_validator
	import b64v_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_byte,
	input  logic              char_present,
	input  logic              end_of_string,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_valid,
	output logic [SIZE_W-1:0] byte_count,
	output logic [2:0]        fail_code
);

	logic [LEN_W-1:0]  max_encoded_q;
	logic [SIZE_W-1:0] min_decoded_q;
	logic [SIZE_W-1:0] max_decoded_q;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              present_s1;
	logic              end_s1;

	logic [LEN_W-1:0]  len_q;
	logic [1:0]        pad_q;
	logic              err_q;
	logic [5:0]        sextet_q;

	logic              out_valid_q;
	logic              is_valid_q;
	logic [SIZE_W-1:0] size_q;
	fail_t             fail_q;

	logic              s1_hold;
	logic              s1_step;
	logic              res_load;
	logic [LEN_W-1:0]  lim;
	sextet_t           sx;
	logic [LEN_W-1:0]  len_d;
	logic [1:0]        pad_d;
	logic              err_d;
	logic [5:0]        sextet_d;
	logic [SIZE_W-1:0] size_d;
	fail_t             fail_d;

	// Config registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_encoded_q <= MAX_CHARS_C;
			min_decoded_q <= SIZE_W'(1);
			max_decoded_q <= SIZE_W'(768);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAX_ENCODED: max_encoded_q <= cfg_data;
				REG_MIN_DECODED: min_decoded_q <= cfg_data[SIZE_W-1:0];
				REG_MAX_DECODED: max_decoded_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Hold an end beat in s1 while the result register is full and stalled.
	assign s1_hold  = valid_s1 && end_s1 && out_valid_q && out_stall;
	assign s1_step  = valid_s1 && !s1_hold;
	assign res_load = s1_step && end_s1;
	assign in_stall = s1_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!s1_hold) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !s1_hold) begin
			char_s1    <= char_byte;
			present_s1 <= char_present;
			end_s1     <= end_of_string;
		end
	end

	assign lim = (max_encoded_q < MAX_CHARS_C) ? max_encoded_q : MAX_CHARS_C;
	assign sx  = sextet_of(char_s1);

	// Fold the character into the string state.
	always_comb begin
		len_d    = len_q;
		pad_d    = pad_q;
		err_d    = err_q;
		sextet_d = sextet_q;
		if (present_s1) begin
			if (len_q <= lim) begin
				len_d = len_q + LEN_W'(1);
			end
			if (char_s1 == PAD_CHAR) begin
				if (pad_q >= 2'd2) begin
					err_d = 1'b1;
				end else begin
					pad_d = pad_q + 2'd1;
				end
			end else if (!sx.ok || pad_q != 2'd0) begin
				err_d = 1'b1;
			end else begin
				sextet_d = sx.value;
			end
		end
	end

	// Verdict on the updated state.
	always_comb begin
		size_d = '0;
		fail_d = FAIL_NONE;
		if (len_d == '0) begin
			fail_d = FAIL_EMPTY;
		end else if (len_d > lim) begin
			fail_d = FAIL_TOO_LONG;
		end else if (len_d[1:0] != 2'd0) begin
			fail_d = FAIL_LEN_MOD4;
		end else begin
			// len is at most 1024 here, so three bytes per quad stays within 768.
			size_d = SIZE_W'({len_d[LEN_W-1:2], 1'b0}) + SIZE_W'(len_d[LEN_W-1:2])
				- SIZE_W'(pad_d);
			if (err_d) begin
				fail_d = FAIL_BAD_CHAR;
			end else if ((pad_d == 2'd2 && sextet_d[3:0] != 4'd0) ||
					(pad_d == 2'd1 && sextet_d[1:0] != 2'd0)) begin
				fail_d = FAIL_TAIL;
			end else if (size_d < min_decoded_q || size_d > max_decoded_q) begin
				fail_d = FAIL_SIZE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pad_q    <= '0;
			err_q    <= 1'b0;
			sextet_q <= '0;
		end else if (s1_step) begin
			if (end_s1) begin
				len_q    <= '0;
				pad_q    <= '0;
				err_q    <= 1'b0;
				sextet_q <= '0;
			end else begin
				len_q    <= len_d;
				pad_q    <= pad_d;
				err_q    <= err_d;
				sextet_q <= sextet_d;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			is_valid_q <= (fail_d == FAIL_NONE);
			size_q     <= size_d;
			fail_q     <= fail_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_valid   = is_valid_q;
	assign byte_count = size_q;
	assign fail_code  = fail_q;

	`ASSERT_CLK(a_stall_cause, !in_stall || (out_valid_q && out_stall), "stall without verdict")
	`ASSERT_CLK(a_len_sat, len_q <= MAX_CHARS_C + LEN_W'(1), "length count overran")
	`ASSERT_CLK(a_pad_sat, pad_q <= 2'd2, "padding count above two")
	`ASSERT_NEXT(a_clear, res_load, len_q == '0 && pad_q == '0 && !err_q, "state not cleared")

endmodule
